// ----- src/cidt_pkg.sv -----
// Types and codes shared by the CAN ID range dispatch table.
package cidt_pkg;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  typedef enum logic [2:0] {
    STS_HIT      = 3'd0,
    STS_MISS     = 3'd1,
    STS_INSERTED = 3'd2,
    STS_OVERLAP  = 3'd3,
    STS_FULL     = 3'd4,
    STS_INVERTED = 3'd5
  } cidt_status_e;

  typedef struct packed {
    logic        opcode;
    logic [2:0]  bus_index;
    logic [10:0] frame_id;
    logic [10:0] range_low;
    logic [10:0] range_high;
    logic [7:0]  handle_in;
  } cidt_req_t;

  typedef struct packed {
    cidt_status_e status;
    logic [7:0]   handle_out;
    logic [5:0]   used_count;
  } cidt_rsp_t;

  typedef struct packed {
    logic [2:0]  bus;
    logic [10:0] low;
    logic [10:0] high;
    logic [7:0]  handle;
  } cidt_entry_t;

endpackage

// ----- src/cidt_mem.sv -----
// Entry store: one write port, one registered read port.
module cidt_mem
  import cidt_pkg::*;
#(
  parameter int Depth = 32,
  parameter int AddrW = 5
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AddrW-1:0]  waddr_i,
  input  cidt_entry_t       wdata_i,
  input  logic              re_i,
  input  logic [AddrW-1:0]  raddr_i,
  output cidt_entry_t       rdata_o
);

  cidt_entry_t mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- src/cidt_match.sv -----
// Range compare of one stored entry against the request window.
module cidt_match
  import cidt_pkg::*;
(
  input  cidt_entry_t  entry_i,
  input  logic [2:0]   bus_i,
  input  logic [10:0]  win_lo_i,
  input  logic [10:0]  win_hi_i,
  output logic         match_o
);

  // a lookup uses a one-ID window, so hit and overlap share this test
  assign match_o = (entry_i.bus == bus_i) &&
                   (entry_i.low <= win_hi_i) &&
                   (entry_i.high >= win_lo_i);

endmodule

// ----- src/can_id_range_dispatch_table.sv -----
// A request steps from S_IDLE through S_SCAN to S_FIN; done_o is registered from S_FIN.
// An inverted insert skips S_SCAN. A new request is taken only back in S_IDLE (busy low).
// S_SCAN reads the held ranges through the single memory read port, one entry per cycle,
// and with an empty table it goes on to S_FIN without a read.
// Reset clears the fill count, so the table is empty at once; no clearing pass.
// done_o marks rsp_o for exactly one cycle; rsp_o keeps its value until the next result.
module can_id_range_dispatch_table
  import cidt_pkg::*;
#(
  parameter int TABLE_ENTRIES = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  cidt_req_t  req_i,
  output logic       done_o,
  output cidt_rsp_t  rsp_o
);

  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_ENTRIES);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] idx_q, idx_d;
  logic          pend_q, pend_d;
  logic          found_q, found_d;
  logic [7:0]    hnd_q, hnd_d;
  cidt_req_t     req_q, req_d;
  logic          done_q, done_d;
  cidt_rsp_t     rsp_q, rsp_d;

  logic          rd_en;
  logic          wr_en;
  cidt_entry_t   rd_data;
  cidt_entry_t   wr_data;
  logic          hit;
  logic [10:0]   win_lo;
  logic [10:0]   win_hi;
  logic          inverted;
  logic [CW-1:0] cnt_after;
  logic [5:0]    used;

  assign win_lo   = (req_q.opcode == OP_LOOKUP) ? req_q.frame_id : req_q.range_low;
  assign win_hi   = (req_q.opcode == OP_LOOKUP) ? req_q.frame_id : req_q.range_high;
  assign inverted = req_q.range_low > req_q.range_high;

  assign wr_data.bus    = req_q.bus_index;
  assign wr_data.low    = req_q.range_low;
  assign wr_data.high   = req_q.range_high;
  assign wr_data.handle = req_q.handle_in;

  cidt_mem #(
    .Depth (TABLE_ENTRIES),
    .AddrW (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (rd_data)
  );

  cidt_match u_match (
    .entry_i  (rd_data),
    .bus_i    (req_q.bus_index),
    .win_lo_i (win_lo),
    .win_hi_i (win_hi),
    .match_o  (hit)
  );

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    pend_d    = 1'b0;
    found_d   = found_q;
    hnd_d     = hnd_q;
    req_d     = req_q;
    done_d    = 1'b0;
    rsp_d     = rsp_q;
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    cnt_after = cnt_q;
    used      = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          req_d   = req_i;
          idx_d   = '0;
          found_d = 1'b0;
          hnd_d   = '0;
          state_d = (req_i.opcode == OP_INSERT && req_i.range_low > req_i.range_high)
                    ? S_FIN : S_SCAN;
        end
      end
      S_SCAN: begin
        if (idx_q < cnt_q) begin
          rd_en  = 1'b1;
          pend_d = 1'b1;
          idx_d  = idx_q + 1'b1;
        end
        if (pend_q && hit && !found_q) begin
          found_d = 1'b1;
          hnd_d   = rd_data.handle;
        end
        if (!(idx_q < cnt_q) && !pend_q) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (req_q.opcode == OP_LOOKUP) begin
          rsp_d.status     = found_q ? STS_HIT : STS_MISS;
          rsp_d.handle_out = found_q ? hnd_q : 8'd0;
        end else begin
          rsp_d.handle_out = 8'd0;
          if (inverted) begin
            rsp_d.status = STS_INVERTED;
          end else if (found_q) begin
            rsp_d.status = STS_OVERLAP;
          end else if (cnt_q == FULL_CNT) begin
            rsp_d.status = STS_FULL;
          end else begin
            rsp_d.status = STS_INSERTED;
            wr_en        = 1'b1;
            cnt_after    = cnt_q + 1'b1;
          end
        end
        used             = (32'(cnt_after) > 32'd63) ? 6'd63 : 6'(cnt_after);
        rsp_d.used_count = used;
        cnt_d            = cnt_after;
        done_d           = 1'b1;
        state_d          = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      idx_q   <= '0;
      pend_q  <= 1'b0;
      found_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      pend_q  <= pend_d;
      found_q <= found_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hnd_q <= hnd_d;
    req_q <= req_d;
    rsp_q <= rsp_d;
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FULL_CNT)
    else $error("fill count exceeds table size");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == S_FIN))
    else $error("result without a finishing cycle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_insert_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status == STS_INSERTED) |-> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("insert did not advance fill count");

  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> (idx_q < cnt_q))
    else $error("read beyond filled entries");
`endif

endmodule
